/* rtl/core/square_wave_tone_generator_macros.svh */
// assertion macros for the square wave tone generator
`ifndef SQUARE_WAVE_TONE_GENERATOR_MACROS_SVH
`define SQUARE_WAVE_TONE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is held
`define SWTG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tone generator assertion failed");

// check that also holds during reset
`define SWTG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tone generator assertion failed");

`else

`define SWTG_ASSERT(label, clk, rst_n, prop)
`define SWTG_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/core/swtg_pkg.sv */
// shared types and constants of the square wave tone generator
package swtg_pkg;

    localparam int PIN_W   = 6;
    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 32;
    localparam int COUNT_W = 16;
    localparam int DEN_W   = FREQ_W + 1;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_MS    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PIN  = 2'd1,
        ST_BAD_FREQ = 2'd2,
        ST_BUSY     = 2'd3
    } t_status;

    typedef struct packed {
        logic exec;
        logic div_start;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic needs_div;
        logic div_done;
    } t_sts;

endpackage

/* rtl/core/swtg_ctrl.sv */
// controller of the tone generator: handshakes and divider sequencing
`include "square_wave_tone_generator_macros.svh"

module swtg_ctrl
    import swtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;
    logic   in_accept;

    always_comb begin
        slot_free   = !r_out_valid || !i_stall;
        o_stall     = (r_state != S_IDLE) || !slot_free;
        in_accept   = i_valid && !o_stall;
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_sts.needs_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        o_cmd.exec  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    `SWTG_ASSERT(a_commit_after_div, i_clk, i_rst_n, o_cmd.commit |-> (r_state == S_DIV) && i_sts.div_done)
    `SWTG_ASSERT(a_result_has_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(o_cmd.exec || o_cmd.commit))
    `SWTG_ASSERT(a_single_action, i_clk, i_rst_n, !(o_cmd.exec && (o_cmd.div_start || o_cmd.commit)))

endmodule

/* rtl/core/swtg_dp.sv */
// datapath of the tone generator: tone state, half-period divider, result register
`include "square_wave_tone_generator_macros.svh"

module swtg_dp
    import swtg_pkg::*;
#(
    parameter int TIMER_CLOCK_HZ = 1000000,
    parameter int MIN_FREQUENCY  = 16,
    parameter int MAX_FREQUENCY  = 20000,
    parameter int PIN_COUNT      = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [1:0]        i_kind,
    input  logic [PIN_W-1:0]  i_pin,
    input  logic [FREQ_W-1:0] i_frequency,
    input  logic [DUR_W-1:0]  i_duration_ms,
    input  logic              i_timer_busy,
    output logic [1:0]        o_status,
    output logic              o_active,
    output logic [PIN_W-1:0]  o_play_pin,
    output logic              o_level
);

    localparam int NUM_W = $clog2(TIMER_CLOCK_HZ + MAX_FREQUENCY + 1);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [PIN_W:0]    PIN_LIM  = (PIN_W + 1)'(PIN_COUNT);
    localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(MIN_FREQUENCY);
    localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(MAX_FREQUENCY);
    localparam logic [NUM_W-1:0]  CLK_NUM  = NUM_W'(TIMER_CLOCK_HZ);

    // tone state
    logic               r_playing, n_playing;
    logic [PIN_W-1:0]   r_pin, n_pin;
    logic               r_level, n_level;
    logic [COUNT_W-1:0] r_reload, n_reload;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [DUR_W-1:0]   r_elapsed, n_elapsed;
    logic [DUR_W-1:0]   r_length, n_length;
    t_status            r_status, n_status;

    // start held during division
    logic [PIN_W-1:0]   r_st_pin;
    logic [DUR_W-1:0]   r_st_dur;

    // divider: dividend shifts out as quotient shifts in
    logic [NUM_W-1:0]   r_nq;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     trial;
    logic               q_bit;

    // result register
    t_status            r_o_status;
    logic               r_o_active;
    logic [PIN_W-1:0]   r_o_pin;
    logic               r_o_level;

    logic               pin_bad;
    logic               freq_zero;
    logic               freq_bad;
    logic               pin_match;
    logic               busy;
    logic               wrap;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] neg_ticks;

    always_comb begin
        pin_bad   = {1'b0, i_pin} >= PIN_LIM;
        freq_zero = i_frequency == '0;
        freq_bad  = (i_frequency < FREQ_MIN) || (i_frequency > FREQ_MAX);
        pin_match = r_playing && (r_pin == i_pin);
        busy      = (r_playing && (r_pin != i_pin)) || (!r_playing && i_timer_busy);
        o_sts.needs_div = (t_kind'(i_kind) == KIND_START) && !pin_bad && !freq_zero
                          && !freq_bad && !busy;
        o_sts.div_done  = r_cnt == '0;
    end

    always_comb begin
        shifted = {r_rem, r_nq[NUM_W-1]};
        trial   = shifted - {1'b0, r_den};
        q_bit   = !trial[DEN_W];
    end

    always_comb begin
        count_inc = r_count + 1'b1;
        wrap      = r_count == '1;
        neg_ticks = '0 - r_nq[COUNT_W-1:0];
        n_playing = r_playing;
        n_pin     = r_pin;
        n_level   = r_level;
        n_reload  = r_reload;
        n_count   = r_count;
        n_elapsed = r_elapsed;
        n_length  = r_length;
        n_status  = r_status;
        if (i_cmd.exec) begin
            case (t_kind'(i_kind))
                KIND_START: begin
                    if (pin_bad) begin
                        n_status = ST_BAD_PIN;
                    end else if (freq_zero) begin
                        if (pin_match) begin
                            n_playing = 1'b0;
                            n_level   = 1'b0;
                        end
                        n_status = ST_OK;
                    end else if (freq_bad) begin
                        n_status = ST_BAD_FREQ;
                    end else if (busy) begin
                        n_status = ST_BUSY;
                    end
                end
                KIND_STOP: begin
                    if (pin_match) begin
                        n_playing = 1'b0;
                        n_level   = 1'b0;
                    end
                end
                KIND_TICK: begin
                    if (r_playing) begin
                        if (wrap) begin
                            n_count = r_reload;
                            if ((r_length != '0) && (r_elapsed >= r_length)) begin
                                n_playing = 1'b0;
                                n_level   = 1'b0;
                            end else begin
                                n_level = !r_level;
                            end
                        end else begin
                            n_count = count_inc;
                        end
                    end
                end
                KIND_MS: begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                default: begin
                    n_elapsed = r_elapsed;
                end
            endcase
        end else if (i_cmd.commit) begin
            n_reload  = neg_ticks;
            n_count   = neg_ticks;
            n_pin     = r_st_pin;
            n_level   = 1'b0;
            n_playing = 1'b1;
            n_elapsed = '0;
            n_length  = r_st_dur;
            n_status  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing <= 1'b0;
            r_pin     <= '0;
            r_level   <= 1'b0;
            r_reload  <= '0;
            r_count   <= '0;
            r_elapsed <= '0;
            r_length  <= '0;
            r_status  <= ST_OK;
            r_cnt     <= '0;
        end else begin
            r_playing <= n_playing;
            r_pin     <= n_pin;
            r_level   <= n_level;
            r_reload  <= n_reload;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_length  <= n_length;
            r_status  <= n_status;
            if (i_cmd.div_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_nq     <= CLK_NUM + NUM_W'(i_frequency);
            r_den    <= {i_frequency, 1'b0};
            r_rem    <= '0;
            r_st_pin <= i_pin;
            r_st_dur <= i_duration_ms;
        end else if (i_cmd.div_step) begin
            r_nq  <= {r_nq[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
        if (i_cmd.exec || i_cmd.commit) begin
            r_o_status <= n_status;
            r_o_active <= n_playing;
            r_o_pin    <= n_pin;
            r_o_level  <= n_level;
        end
    end

    assign o_status   = r_o_status;
    assign o_active   = r_o_active;
    assign o_play_pin = r_o_pin;
    assign o_level    = r_o_level;

    `SWTG_ASSERT_ALWAYS(a_level_needs_tone, i_clk, r_level |-> r_playing)
    `SWTG_ASSERT(a_commit_starts_low, i_clk, i_rst_n, i_cmd.commit |=> r_playing && !r_level && (r_status == ST_OK))
    `SWTG_ASSERT(a_div_runs, i_clk, i_rst_n, i_cmd.div_start |=> !o_sts.div_done)

endmodule

/* rtl/core/square_wave_tone_generator.sv */
// top level of the square wave tone generator
// Every transaction on the input (start, stop, timer-clock tick or millisecond
// tick) gives exactly one result transaction carrying the last start status, whether a
// tone is playing, the tone pin and its present level. Stops, ticks and refused
// starts need no division, so timer-clock ticks can arrive every cycle while the output
// is not stalled. A start that passes its checks holds the input stalled while
// the bit-serial restoring divider works out the half-period tick count one
// quotient bit per cycle, and while the previous result still waits at the
// output. A finished result waits in an output register, and the
// next transaction is taken in the same cycle that result leaves.
module square_wave_tone_generator
    import swtg_pkg::*;
#(
    parameter int TIMER_CLOCK_HZ = 1000000,
    parameter int MIN_FREQUENCY  = 16,
    parameter int MAX_FREQUENCY  = 20000,
    parameter int PIN_COUNT      = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_kind,
    input  logic [PIN_W-1:0]  i_pin,
    input  logic [FREQ_W-1:0] i_frequency,
    input  logic [DUR_W-1:0]  i_duration_ms,
    input  logic              i_timer_busy,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic              o_active,
    output logic [PIN_W-1:0]  o_play_pin,
    output logic              o_level
);

    t_cmd cmd;
    t_sts sts;

    swtg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    swtg_dp #(
        .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
        .MIN_FREQUENCY  (MIN_FREQUENCY),
        .MAX_FREQUENCY  (MAX_FREQUENCY),
        .PIN_COUNT      (PIN_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_pin         (i_pin),
        .i_frequency   (i_frequency),
        .i_duration_ms (i_duration_ms),
        .i_timer_busy  (i_timer_busy),
        .o_status      (o_status),
        .o_active      (o_active),
        .o_play_pin    (o_play_pin),
        .o_level       (o_level)
    );

endmodule

/* test/square_wave_tone_generator_tb.sv */
// testbench for the square wave tone generator: random and directed transactions against a predictor
`timescale 1ns / 1ps

module square_wave_tone_generator_tb;
    import swtg_pkg::*;

    localparam int TIMER_CLOCK_HZ = 1000000;
    localparam int MIN_FREQUENCY  = 16;
    localparam int MAX_FREQUENCY  = 20000;
    localparam int PIN_COUNT      = 64;
    localparam int CLK_PERIOD     = 10;
    localparam int ITEM_TARGET    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PRINT_LIMIT    = 100;

    typedef struct packed {
        t_kind              kind;
        logic [PIN_W-1:0]   pin;
        logic [FREQ_W-1:0]  frequency;
        logic [DUR_W-1:0]   duration;
        logic               busy;
    } t_tone_item;

    typedef struct packed {
        t_status            status;
        logic               active;
        logic [PIN_W-1:0]   play_pin;
        logic               level;
    } t_tone_state;

    class tone_scoreboard;
        logic               playing;
        logic [PIN_W-1:0]   out_pin;
        logic               out_level;
        logic [COUNT_W-1:0] reload_val;
        logic [COUNT_W-1:0] period_cnt;
        logic [DUR_W-1:0]   elapsed;
        logic [DUR_W-1:0]   length;
        t_status            last_status;
        t_tone_state        expected_q[$];
        int unsigned        n_errors;
        int unsigned        n_checked;
        int unsigned        n_started;
        int unsigned        n_toggles;
        int unsigned        n_timed_out;

        function new();
            playing     = 1'b0;
            out_pin     = '0;
            out_level   = 1'b0;
            reload_val  = '0;
            period_cnt  = '0;
            elapsed     = '0;
            length      = '0;
            last_status = ST_OK;
            n_errors    = 0;
            n_checked   = 0;
            n_started   = 0;
            n_toggles   = 0;
            n_timed_out = 0;
        endfunction

        function void stop_on(logic [PIN_W-1:0] pin);
            if (playing && out_pin == pin) begin
                playing   = 1'b0;
                out_level = 1'b0;
            end
        endfunction

        function void start_tone(t_tone_item it);
            int unsigned f;
            int unsigned ticks;
            f = it.frequency;
            if (it.pin >= PIN_COUNT) begin
                last_status = ST_BAD_PIN;
                return;
            end
            if (f == 0) begin
                stop_on(it.pin);
                last_status = ST_OK;
                return;
            end
            if (f < MIN_FREQUENCY || f > MAX_FREQUENCY) begin
                last_status = ST_BAD_FREQ;
                return;
            end
            if ((playing && out_pin != it.pin) || (!playing && it.busy)) begin
                last_status = ST_BUSY;
                return;
            end
            ticks       = (TIMER_CLOCK_HZ + f) / (2 * f);
            reload_val  = COUNT_W'(32'h10000 - ticks);
            period_cnt  = reload_val;
            out_pin     = it.pin;
            out_level   = 1'b0;
            playing     = 1'b1;
            elapsed     = '0;
            length      = it.duration;
            last_status = ST_OK;
            n_started++;
        endfunction

        function void count_tick();
            if (!playing)
                return;
            period_cnt = period_cnt + 1'b1;
            if (period_cnt != '0)
                return;
            period_cnt = reload_val;
            if (length != '0 && elapsed >= length) begin
                playing   = 1'b0;
                out_level = 1'b0;
                n_timed_out++;
            end else begin
                out_level = ~out_level;
                n_toggles++;
            end
        endfunction

        function void note_item(t_tone_item it);
            t_tone_state r;
            case (it.kind)
                KIND_START: start_tone(it);
                KIND_STOP:  stop_on(it.pin);
                KIND_TICK:  count_tick();
                default:    elapsed = elapsed + 1'b1;
            endcase
            r.status   = last_status;
            r.active   = playing;
            r.play_pin = out_pin;
            r.level    = out_level;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (n_errors < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
            n_errors++;
        endtask

        task check_result(t_tone_state got);
            t_tone_state want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0h with no transaction outstanding", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d expected %0d at result %0d",
                                          got.status, want.status, n_checked));
            if (got.active !== want.active)
                report_mismatch($sformatf("active got %0b expected %0b at result %0d",
                                          got.active, want.active, n_checked));
            if (got.play_pin !== want.play_pin)
                report_mismatch($sformatf("play_pin got %0d expected %0d at result %0d",
                                          got.play_pin, want.play_pin, n_checked));
            if (got.level !== want.level)
                report_mismatch($sformatf("level got %0b expected %0b at result %0d",
                                          got.level, want.level, n_checked));
            n_checked++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_kind;
    logic [PIN_W-1:0]   i_pin;
    logic [FREQ_W-1:0]  i_frequency;
    logic [DUR_W-1:0]   i_duration_ms;
    logic               i_timer_busy;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic               o_active;
    logic [PIN_W-1:0]   o_play_pin;
    logic               o_level;

    tone_scoreboard     sb;
    bit                 idling_on = 1'b1;
    bit                 hold_off_req = 1'b0;
    int unsigned        n_sent = 0;
    int unsigned        quiet_cycles = 0;

    square_wave_tone_generator #(
        .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
        .MIN_FREQUENCY  (MIN_FREQUENCY),
        .MAX_FREQUENCY  (MAX_FREQUENCY),
        .PIN_COUNT      (PIN_COUNT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_pin         (i_pin),
        .i_frequency   (i_frequency),
        .i_duration_ms (i_duration_ms),
        .i_timer_busy  (i_timer_busy),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_active      (o_active),
        .o_play_pin    (o_play_pin),
        .o_level       (o_level)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        t_tone_item  seen;
        t_tone_state got;
        if (i_rst_n === 1'b1) begin
            if (i_valid && !o_stall) begin
                seen.kind      = t_kind'(i_kind);
                seen.pin       = i_pin;
                seen.frequency = i_frequency;
                seen.duration  = i_duration_ms;
                seen.busy      = i_timer_busy;
                sb.note_item(seen);
            end
            if (o_valid === 1'b1 && !i_stall) begin
                got.status   = t_status'(o_status);
                got.active   = o_active;
                got.play_pin = o_play_pin;
                got.level    = o_level;
                sb.check_result(got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
            $display("FAIL square_wave_tone_generator");
            $finish;
        end
    end

    // result side: random stall, plus one long hold-off on request
    initial begin : receiver
        int unsigned hold;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                i_stall <= 1'b1;
                hold--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= idling_on && ($urandom_range(0, 99) < 32);
            end
        end
    end

    function automatic t_tone_item make_item(t_kind kind, logic [PIN_W-1:0] pin,
                                             logic [FREQ_W-1:0] freq,
                                             logic [DUR_W-1:0] dur, logic busy);
        t_tone_item it;
        it.kind      = kind;
        it.pin       = pin;
        it.frequency = freq;
        it.duration  = dur;
        it.busy      = busy;
        return it;
    endfunction

    function automatic t_tone_item filler(t_kind kind);
        return make_item(kind, PIN_W'($urandom), FREQ_W'($urandom), $urandom, 1'($urandom));
    endfunction

    function automatic logic [FREQ_W-1:0] pick_tone_freq();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return FREQ_W'($urandom_range(10000, MAX_FREQUENCY));
        else if (r < 85)
            return FREQ_W'($urandom_range(1000, MAX_FREQUENCY));
        else if (r < 95)
            return FREQ_W'($urandom_range(MIN_FREQUENCY, MAX_FREQUENCY));
        else
            return ($urandom_range(0, 1) != 0) ? FREQ_W'(MIN_FREQUENCY) : FREQ_W'(MAX_FREQUENCY);
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return DUR_W'($urandom_range(1, 3));
        else if (r < 75)
            return '0;
        else if (r < 90)
            return DUR_W'($urandom_range(4, 20));
        else
            return $urandom;
    endfunction

    function automatic logic [FREQ_W-1:0] pick_any_freq();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return FREQ_W'(MIN_FREQUENCY - 1);
            2: return FREQ_W'(MIN_FREQUENCY);
            3: return FREQ_W'(MAX_FREQUENCY);
            4: return FREQ_W'(MAX_FREQUENCY + 1);
            5: return '1;
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    task automatic send_item(t_tone_item it);
        while (idling_on && $urandom_range(0, 99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= it.kind;
        i_pin         <= it.pin;
        i_frequency   <= it.frequency;
        i_duration_ms <= it.duration;
        i_timer_busy  <= it.busy;
        do
            @(posedge i_clk);
        while (o_stall);
        n_sent++;
    endtask

    // well-formed start followed by a burst of ticks with a few stray commands
    task automatic play_sequence();
        t_tone_item  it;
        logic [PIN_W-1:0] pin;
        int unsigned burst;
        int unsigned r;
        pin = PIN_W'($urandom);
        it = make_item(KIND_START, pin, pick_tone_freq(), pick_duration(),
                       $urandom_range(0, 9) == 0);
        send_item(it);
        burst = $urandom_range(20, 160);
        repeat (burst) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                it = filler(KIND_TICK);
            end else if (r < 93) begin
                it = filler(KIND_MS);
            end else if (r < 96) begin
                it = filler(KIND_STOP);
                if ($urandom_range(0, 1) != 0)
                    it.pin = pin;
            end else begin
                it = make_item(KIND_START, PIN_W'($urandom), pick_any_freq(), pick_duration(),
                               1'($urandom));
                if ($urandom_range(0, 1) != 0)
                    it.pin = pin;
            end
            send_item(it);
        end
        if ($urandom_range(0, 1) != 0) begin
            it = filler(KIND_STOP);
            it.pin = pin;
            send_item(it);
        end
    endtask

    task automatic send_noise();
        t_tone_item it;
        repeat ($urandom_range(1, 8)) begin
            it = filler(t_kind'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) != 0)
                it.frequency = pick_any_freq();
            send_item(it);
        end
    endtask

    initial begin : stimulus
        bit pressure_done;
        pressure_done = 1'b0;
        sb = new();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_START;
        i_pin         <= '0;
        i_frequency   <= '0;
        i_duration_ms <= '0;
        i_timer_busy  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero frequency with nothing playing, out of range frequencies, busy timer
        send_item(make_item(KIND_START, 6'd0, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_START, 6'd1, FREQ_W'(MIN_FREQUENCY - 1), 32'd5, 1'b0));
        send_item(make_item(KIND_START, 6'd1, FREQ_W'(MAX_FREQUENCY + 1), 32'd5, 1'b0));
        send_item(make_item(KIND_START, 6'd1, 16'hffff, 32'hffff_ffff, 1'b1));
        send_item(make_item(KIND_START, 6'd5, FREQ_W'(MAX_FREQUENCY), 32'd2, 1'b1));
        // tone on the top pin, then refusals and ignored commands while it plays
        send_item(make_item(KIND_START, 6'd63, FREQ_W'(MAX_FREQUENCY), 32'd2, 1'b0));
        send_item(make_item(KIND_START, 6'd7, 16'd1000, 32'd0, 1'b0));
        send_item(make_item(KIND_STOP, 6'd7, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_TICK, 6'd0, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_MS, 6'd63, 16'hffff, 32'hffff_ffff, 1'b1));
        // restart on the same pin ignores the busy flag
        send_item(make_item(KIND_START, 6'd63, FREQ_W'(MIN_FREQUENCY), 32'hffff_ffff, 1'b1));
        send_item(make_item(KIND_TICK, 6'd63, 16'hffff, 32'hffff_ffff, 1'b1));
        send_item(make_item(KIND_START, 6'd63, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_STOP, 6'd63, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_TICK, 6'd0, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_MS, 6'd0, 16'd0, 32'd0, 1'b0));
        send_item(make_item(KIND_START, 6'd0, FREQ_W'(MAX_FREQUENCY), 32'd0, 1'b0));
        send_item(make_item(KIND_STOP, 6'd0, 16'd0, 32'd0, 1'b0));

        while (n_sent < ITEM_TARGET) begin
            idling_on = !(n_sent >= 700 && n_sent < 1000);
            if (!pressure_done && n_sent >= 1200) begin
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 70)
                play_sequence();
            else
                send_noise();
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions: %0d tones started, %0d level toggles, %0d timed ends",
                 sb.n_checked, sb.n_started, sb.n_toggles, sb.n_timed_out);
        $display("%0d mismatches found", sb.n_errors);
        if (sb.n_errors == 0)
            $display("PASS square_wave_tone_generator");
        else
            $display("FAIL square_wave_tone_generator");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/swtg_pkg.sv
rtl/core/swtg_ctrl.sv
rtl/core/swtg_dp.sv
rtl/core/square_wave_tone_generator.sv
test/square_wave_tone_generator_tb.sv
